### sv/brpe_pkg.sv
// Shared constants and types for the base relocation patch engine.
package brpe_pkg;

  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned OFFS_W    = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [1:0] phase_t;

  localparam phase_t PH_HEADER  = 2'd0;
  localparam phase_t PH_ENTRIES = 2'd1;
  localparam phase_t PH_DONE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LOAD_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIG_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_SIZE  = 2'd2;

  localparam logic [OFFS_W-1:0] HDR_BYTES  = 32'd8;
  localparam logic [3:0]        TYPE_DIR64 = 4'd10;

endpackage

### sv/base_relocation_patch_engine.sv
// Base relocation patch engine: parses a relocation directory byte stream into patch addresses.
//
//   channel | direction | words                    | handshake
//   --------+-----------+--------------------------+-------------------
//   in_     | in        | one directory byte       | tvalid / tready
//   out_    | out       | one 64-bit patch address | tvalid / tready
//   cfg_    | in        | register index and data  | valid / ready
//
// One byte a cycle while the result is taken: a byte is registered on entry, then the parser
// state and the single 64-bit address add settle together, the address into the result
// register. Reset (rst_n low, synchronous) clears the valid flags, the configuration
// registers and the parser to the header phase at offset zero. A stalled result holds the
// parser; the entry register still takes one more byte, so in_tready drops only when both wait.
module base_relocation_patch_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [brpe_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] dir_byte
  input  logic [0:0]                      in_tuser,   // [0] first
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [brpe_pkg::ADDR_W-1:0]     out_tdata,  // [63:0] patch_addr
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [brpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brpe_pkg::ADDR_W-1:0]     cfg_data
);
  import brpe_pkg::*;

  logic [ADDR_W-1:0] load_base_r;
  logic [ADDR_W-1:0] orig_base_r;
  logic [OFFS_W-1:0] dir_size_r;

  logic              d_v_r;
  logic [BYTE_W-1:0] d_byte_r;
  logic              d_first_r;

  phase_t            phase_r, phase_nxt;
  logic [OFFS_W-1:0] stream_off_r, stream_off_nxt;
  logic [OFFS_W-1:0] page_off_r, page_off_nxt;
  logic [OFFS_W-1:0] block_len_r, block_len_nxt;
  logic [OFFS_W-1:0] block_pos_r, block_pos_nxt;
  logic [BYTE_W-1:0] low_byte_r, low_byte_nxt;

  logic              out_v_r, out_v_nxt;
  logic [ADDR_W-1:0] out_data_r;

  logic              out_ok;
  logic              fire;
  logic              hit;
  logic [OFFS_W-1:0] here;
  logic [OFFS_W-1:0] pos_cur;
  phase_t            phase_cur;
  logic [OFFS_W-1:0] pos_inc;
  logic [ADDR_W-1:0] patch_addr;

  assign cfg_ready  = 1'b1;
  assign out_ok     = !out_v_r || out_tready;
  assign fire       = d_v_r && out_ok;
  assign in_tready  = !d_v_r || out_ok;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_base_r <= '0;
      orig_base_r <= '0;
      dir_size_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOAD_BASE: load_base_r <= cfg_data;
        REG_ORIG_BASE: orig_base_r <= cfg_data;
        REG_DIR_SIZE:  dir_size_r  <= cfg_data[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  // entry register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (in_tready) begin
      d_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      d_byte_r  <= in_tdata;
      d_first_r <= in_tuser[0];
    end
  end

  assign patch_addr = load_base_r + {{(ADDR_W-OFFS_W){1'b0}}, page_off_r}
                      + {{(ADDR_W-12){1'b0}}, d_byte_r[3:0], low_byte_r};

  // parser
  always_comb begin
    phase_nxt      = phase_r;
    stream_off_nxt = stream_off_r;
    page_off_nxt   = page_off_r;
    block_len_nxt  = block_len_r;
    block_pos_nxt  = block_pos_r;
    low_byte_nxt   = low_byte_r;
    hit            = 1'b0;

    here      = d_first_r ? '0 : stream_off_r;
    pos_cur   = d_first_r ? '0 : block_pos_r;
    phase_cur = d_first_r ? PH_HEADER : phase_r;
    pos_inc   = pos_cur + 1'b1;

    stream_off_nxt = (here == '1) ? here : here + 1'b1;
    phase_nxt      = phase_cur;
    block_pos_nxt  = pos_cur;

    case (phase_cur)
      PH_HEADER: begin
        if (pos_cur == '0 && here >= dir_size_r) begin
          phase_nxt = PH_DONE;
        end else begin
          if (!pos_cur[2]) begin
            page_off_nxt[8*pos_cur[1:0] +: 8] = d_byte_r;
          end else begin
            block_len_nxt[8*pos_cur[1:0] +: 8] = d_byte_r;
          end
          block_pos_nxt = pos_inc;
          if (pos_inc == HDR_BYTES) begin
            if (block_len_nxt < HDR_BYTES) begin
              phase_nxt = PH_DONE;
            end else if (block_len_nxt == HDR_BYTES) begin
              block_pos_nxt = '0;
            end else begin
              phase_nxt = PH_ENTRIES;
            end
          end
        end
      end
      PH_ENTRIES: begin
        if (!pos_cur[0]) begin
          low_byte_nxt = d_byte_r;
        end else begin
          hit = (d_byte_r[7:4] == TYPE_DIR64) && (load_base_r != orig_base_r);
        end
        block_pos_nxt = pos_inc;
        if (pos_inc >= block_len_r) begin
          phase_nxt     = PH_HEADER;
          block_pos_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      stream_off_r <= '0;
      page_off_r   <= '0;
      block_len_r  <= '0;
      block_pos_r  <= '0;
      low_byte_r   <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      stream_off_r <= stream_off_nxt;
      page_off_r   <= page_off_nxt;
      block_len_r  <= block_len_nxt;
      block_pos_r  <= block_pos_nxt;
      low_byte_r   <= low_byte_nxt;
    end
  end

  // result register
  always_comb begin
    out_v_nxt = out_v_r;
    if (fire) begin
      out_v_nxt = hit;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && hit) begin
      out_data_r <= patch_addr;
    end
  end

`ifndef SYNTH
  a_hdr_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> block_pos_r < HDR_BYTES)
    else $error("header position out of range");

  a_ent_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ENTRIES |-> (block_pos_r >= HDR_BYTES && block_pos_r < block_len_r))
    else $error("entry position outside block");

  a_bases: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> load_base_r != orig_base_r)
    else $error("patch address given with equal bases");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (d_v_r && !out_ok) |=> (d_v_r && $stable(d_byte_r) && $stable(phase_r)))
    else $error("parser moved while result stalled");
`endif

endmodule

### tb/tb_base_relocation_patch_engine.sv
// Self-checking testbench: relocation directory words in, DIR64 patch addresses checked.
module tb_base_relocation_patch_engine;
  import brpe_pkg::*;

  localparam int unsigned CLK_HALF     = 2;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned RANDOM_WORDS = 400;
  localparam int unsigned ENT_OFF_W    = 12;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [BYTE_W-1:0]    in_tdata   = '0;
  logic [0:0]           in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [ADDR_W-1:0]    out_tdata;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [ADDR_W-1:0]    cfg_data   = '0;

  base_relocation_patch_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // parser copy and register shadow
  logic [ADDR_W-1:0] cur_load_base = '0;
  logic [ADDR_W-1:0] cur_orig_base = '0;
  logic [OFFS_W-1:0] cur_dir_size  = '0;
  phase_t            prs_phase     = PH_HEADER;
  logic [OFFS_W-1:0] prs_offset    = '0;
  logic [OFFS_W-1:0] prs_page      = '0;
  logic [OFFS_W-1:0] prs_len       = '0;
  logic [OFFS_W-1:0] prs_pos       = '0;
  logic [BYTE_W-1:0] prs_low       = '0;

  logic [ADDR_W-1:0] pending_patches[$];
  logic [ADDR_W-1:0] want_addr;

  int unsigned error_count     = 0;
  int unsigned dir_words_taken = 0;
  int unsigned patches_seen    = 0;
  int unsigned settings_used   = 0;
  int unsigned idle_cycles     = 0;
  int unsigned burst_left      = 0;
  int unsigned rx_tick         = 0;
  bit          gapping         = 1'b1;
  bit          hold_req        = 1'b0;
  rx_mode_t    rx_mode         = RX_ALWAYS;

  function automatic void advance_reloc_parser(input logic [BYTE_W-1:0] b, input logic first);
    logic [OFFS_W-1:0] here;
    logic [15:0]       entry;
    if (first) begin
      prs_offset = '0;
      prs_phase  = PH_HEADER;
      prs_pos    = '0;
    end
    here = prs_offset;
    if (prs_offset != '1) prs_offset++;
    case (prs_phase)
      PH_HEADER: begin
        if (prs_pos == 0 && here >= cur_dir_size) begin
          prs_phase = PH_DONE;
        end else begin
          if (prs_pos < 4) prs_page[8*prs_pos[1:0] +: 8] = b;
          else prs_len[8*prs_pos[1:0] +: 8] = b;
          prs_pos++;
          if (prs_pos == HDR_BYTES) begin
            if (prs_len < HDR_BYTES) prs_phase = PH_DONE;
            else if (prs_len == HDR_BYTES) prs_pos = '0;
            else prs_phase = PH_ENTRIES;
          end
        end
      end
      PH_ENTRIES: begin
        // header is even-sized, so entry parity follows the block position
        if (!prs_pos[0]) begin
          prs_low = b;
        end else begin
          entry = {b, prs_low};
          if (entry[15:ENT_OFF_W] == TYPE_DIR64 && cur_load_base != cur_orig_base)
            pending_patches.insert(pending_patches.size(),
                                   cur_load_base + 64'(prs_page)
                                   + 64'(entry[ENT_OFF_W-1:0]));
        end
        prs_pos++;
        if (prs_pos >= prs_len) begin
          prs_phase = PH_HEADER;
          prs_pos   = '0;
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      dir_words_taken++;
      advance_reloc_parser(in_tdata, in_tuser[0]);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      patches_seen++;
      if (pending_patches.size() == 0) begin
        $error("patch_addr: unexpected word %h", out_tdata);
        error_count++;
      end else begin
        want_addr = pending_patches.pop_front();
        if (out_tdata !== want_addr) begin
          $error("patch_addr: expected %h, actual %h", want_addr, out_tdata);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[base_relocation_patch_engine] ERROR");
      $finish;
    end
  end

  // result side: long hold on request, otherwise its own stall pattern
  initial begin
    forever begin
      @(posedge clk);
      rx_tick++;
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_tready <= 1'b1;
          RX_RANDOM: out_tready <= ($urandom_range(0, 2) != 0);
          default:   out_tready <= (rx_tick % 7) > 1;
        endcase
      end
    end
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LOAD_BASE: cur_load_base = val;
      REG_ORIG_BASE: cur_orig_base = val;
      REG_DIR_SIZE:  cur_dir_size  = val[OFFS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [ADDR_W-1:0] load_base,
                               input logic [ADDR_W-1:0] orig_base,
                               input logic [OFFS_W-1:0] dir_size);
    write_reg(REG_LOAD_BASE, load_base);
    write_reg(REG_ORIG_BASE, orig_base);
    write_reg(REG_DIR_SIZE, {$urandom, dir_size});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_word(input logic [BYTE_W-1:0] b, input logic first);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gapping ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid   <= 1'b1;
    in_tdata    <= b;
    in_tuser[0] <= first;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_patches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // well-formed blocks mostly; noise, short sizes and truncation otherwise
  task automatic send_random_directory();
    logic [BYTE_W-1:0] dir_q[$];
    int unsigned       kind;
    int unsigned       n_ent;
    int unsigned       cut;
    logic [OFFS_W-1:0] page;
    logic [OFFS_W-1:0] blen;
    logic [15:0]       entry;
    bit                odd;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 24)) dir_q.insert(dir_q.size(), BYTE_W'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 7))
          0:       page = '0;
          1:       page = '1;
          default: page = $urandom;
        endcase
        n_ent = $urandom_range(0, 6);
        odd   = ($urandom_range(0, 3) == 0);
        blen  = HDR_BYTES + 2 * n_ent + odd;
        if (kind == 1 && $urandom_range(0, 1)) blen = $urandom_range(0, 7);
        for (int i = 0; i < 4; i++) dir_q.insert(dir_q.size(), page[8*i +: 8]);
        for (int i = 0; i < 4; i++) dir_q.insert(dir_q.size(), blen[8*i +: 8]);
        repeat (n_ent) begin
          entry[15:ENT_OFF_W]  = ($urandom_range(0, 3) != 0) ? TYPE_DIR64
                                                             : 4'($urandom_range(0, 15));
          entry[ENT_OFF_W-1:0] = ENT_OFF_W'($urandom);
          dir_q.insert(dir_q.size(), entry[7:0]);
          dir_q.insert(dir_q.size(), entry[15:8]);
        end
        if (odd) dir_q.insert(dir_q.size(), BYTE_W'($urandom));
      end
      if ($urandom_range(0, 1)) begin
        page = $urandom;
        blen = $urandom_range(0, 7);
        for (int i = 0; i < 4; i++) dir_q.insert(dir_q.size(), page[8*i +: 8]);
        for (int i = 0; i < 4; i++) dir_q.insert(dir_q.size(), blen[8*i +: 8]);
      end
      if (kind == 2) begin
        cut = $urandom_range(1, dir_q.size());
        while (dir_q.size() > cut) void'(dir_q.pop_back());
      end
    end
    foreach (dir_q[i])
      send_word(dir_q[i], i == 0 || (kind == 0 && $urandom_range(0, 15) == 0));
  endtask

  // no first mark after reset; wrapping address, non-DIR64 entry, odd trailing
  // byte, then a short block size and an ignored word
  task automatic test_block_edges();
    logic [BYTE_W-1:0] seq[$] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0D, 8'h00, 8'h00, 8'h00,
                                  8'hFF, 8'hAF, 8'h00, 8'h30, 8'h5A,
                                  8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00,
                                  8'hA5};
    load_settings('1, '0, 32'd20);
    foreach (seq[i]) send_word(seq[i], 1'b0);
    settle();
  endtask

  // header starting at or past the directory size
  task automatic test_past_end();
    load_settings(rand64(), rand64(), '0);
    send_word(BYTE_W'($urandom), 1'b1);
    send_word(BYTE_W'($urandom), 1'b0);
    send_word(BYTE_W'($urandom), 1'b1);
    settle();
  endtask

  task automatic test_random_dirs();
    int unsigned       stop_at;
    int unsigned       phase_no;
    logic [ADDR_W-1:0] base;
    stop_at  = dir_words_taken + RANDOM_WORDS;
    phase_no = 0;
    while (dir_words_taken < stop_at) begin
      case (phase_no % 5)
        0: load_settings(rand64(), rand64(), $urandom_range(24, 120));
        1: load_settings('1, '0, $urandom_range(24, 120));
        2: load_settings('0, '1, $urandom_range(24, 120));
        3: begin
          base = rand64();
          load_settings(base, base, $urandom_range(24, 120));
        end
        default: load_settings(rand64(), rand64(), '1);
      endcase
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      gapping = 1'($urandom_range(0, 1));
      repeat ($urandom_range(2, 5)) send_random_directory();
      settle();
      phase_no++;
    end
  endtask

  // receiver holds off while words keep coming, so the input stalls
  task automatic test_backpressure();
    logic [ADDR_W-1:0] base;
    base = rand64();
    load_settings(base, ~base, '1);
    rx_mode  = RX_ALWAYS;
    gapping  = 1'b0;
    hold_req = 1'b1;
    repeat (4) send_random_directory();
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_block_edges();
    test_past_end();
    test_random_dirs();
    test_backpressure();
    $display("Parsed %0d directory words into %0d patch addresses under %0d register settings,",
             dir_words_taken, patches_seen, settings_used);
    $display("with gaps and stalls on both sides and one long hold on the result side.");
    if (error_count == 0) begin
      $display("[base_relocation_patch_engine] OK");
    end else begin
      $display("[base_relocation_patch_engine] ERROR");
    end
    $finish;
  end

endmodule
